/* hdl/mpool_pkg.sv */
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared constants and types of the 3x3 stride-2 max pool.
// ----------------------------------------------------------------------------
`default_nettype none

package mpool_pkg;

    localparam int CHANNELS  = 64;
    localparam int IN_HEIGHT = 16;
    localparam int IN_WIDTH  = 16;
    localparam int OUT_W     = (IN_WIDTH - 1) / 2 + 1;

    localparam int COL_W  = (IN_WIDTH > 1) ? $clog2(IN_WIDTH) : 1;
    localparam int ROW_W  = (IN_HEIGHT > 1) ? $clog2(IN_HEIGHT) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = (OUT_W > 1) ? $clog2(OUT_W) : 1;

    typedef logic signed [15:0] t_q88;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [CH_W-1:0]    t_chan;

    localparam t_q88 Q88_MIN = 16'sh8000;

    // one request per closed output column of an input row
    typedef struct packed {
        logic  valid;
        t_q88  h;          // horizontal max over the window's columns
        t_addr addr;       // output column
        logic  first_row;  // first row of a channel: store content ignored
        logic  odd_row;
        logic  emit;       // window closes on this row
        logic  last;       // final window of the frame
    } t_req;

endpackage

`default_nettype wire

/* hdl/mpool_if.sv */
// ----------------------------------------------------------------------------
// mpool_if
// Valid/ready stream interfaces for pixels in and pooled values out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpool_pix_if;
    import mpool_pkg::*;
    logic valid;
    logic ready;
    t_q88 pixel_value;
    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mpool_pool_if;
    import mpool_pkg::*;
    logic valid;
    logic ready;
    t_q88 pooled_value;
    logic frame_last;
    modport source (output valid, output pooled_value, output frame_last, input ready);
    modport sink   (input valid, input pooled_value, input frame_last, output ready);
endinterface

`default_nettype wire

/* hdl/mpool_scan.sv */
// ----------------------------------------------------------------------------
// mpool_scan
// Position counters and horizontal running max; issues one store request
// per closed output column.
// ----------------------------------------------------------------------------
`default_nettype none

module mpool_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mpool_pix_if.sink          i_pix,
    input  wire logic          i_room,
    output mpool_pkg::t_req    o_req
);
    import mpool_pkg::*;

    t_col  r_col;
    t_row  r_row;
    t_chan r_chan;
    t_q88  r_run;

    logic  accept;
    logic  col_end;
    logic  row_end;
    logic  chan_end;
    t_q88  pix;
    t_q88  hmax;

    assign i_pix.ready = i_room;
    assign accept      = i_pix.valid && i_room;
    assign pix         = i_pix.pixel_value;
    assign col_end     = (r_col == COL_W'(IN_WIDTH - 1));
    assign row_end     = (r_row == ROW_W'(IN_HEIGHT - 1));
    assign chan_end    = (r_chan == CH_W'(CHANNELS - 1));

    always_comb begin
        if (r_col == '0) begin
            hmax = pix;
        end else begin
            hmax = ($signed(pix) > $signed(r_run)) ? pix : r_run;
        end
        o_req.valid     = accept && (r_col[0] || col_end);
        o_req.h         = hmax;
        o_req.addr      = ADDR_W'(r_col >> 1);
        o_req.first_row = (r_row == '0);
        o_req.odd_row   = r_row[0];
        o_req.emit      = r_row[0] || row_end;
        o_req.last      = col_end && row_end && chan_end;
    end

    // odd column seeds the next window with its own pixel
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_run <= r_col[0] ? pix : hmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row  <= '0;
                    r_chan <= chan_end ? '0 : r_chan + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/mpool_store.sv */
// ----------------------------------------------------------------------------
// mpool_store
// Column store of partial maxima: read on request, merge and write back from
// the registered request stage; output register towards the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module mpool_store (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mpool_pkg::t_req i_req,
    output logic                 o_room,
    mpool_pool_if.source         o_pool
);
    import mpool_pkg::*;

    t_q88 mem [OUT_W];

    t_req r_s1;
    t_q88 r_rd;
    logic r_fwd;
    t_q88 r_fwd_data;
    logic r_o_valid;
    t_q88 r_o_value;
    logic r_o_last;

    logic out_free;
    logic s1_go;
    logic rd_en;
    logic wr_en;
    t_q88 prev;
    t_q88 merged;
    t_q88 wdata;

    assign out_free = !r_o_valid || o_pool.ready;
    assign s1_go    = r_s1.valid && (!r_s1.emit || out_free);
    assign o_room   = !r_s1.valid || s1_go;
    assign rd_en    = i_req.valid && o_room;
    assign wr_en    = s1_go;

    always_comb begin
        if (r_s1.first_row) begin
            prev = Q88_MIN;
        end else if (r_fwd) begin
            prev = r_fwd_data;
        end else begin
            prev = r_rd;
        end
        merged = ($signed(r_s1.h) > $signed(prev)) ? r_s1.h : prev;
        // odd rows leave only their own row for the next window
        wdata  = r_s1.odd_row ? r_s1.h : merged;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1.addr] <= wdata;
        end
        if (rd_en) begin
            r_rd       <= mem[i_req.addr];
            r_fwd      <= wr_en && (r_s1.addr == i_req.addr);
            r_fwd_data <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (o_room) begin
            r_s1.valid <= i_req.valid;
        end
        if (rd_en) begin
            r_s1.h         <= i_req.h;
            r_s1.addr      <= i_req.addr;
            r_s1.first_row <= i_req.first_row;
            r_s1.odd_row   <= i_req.odd_row;
            r_s1.emit      <= i_req.emit;
            r_s1.last      <= i_req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && r_s1.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_pool.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.emit) begin
            r_o_value <= merged;
            r_o_last  <= r_s1.last;
        end
    end

    assign o_pool.valid        = r_o_valid;
    assign o_pool.pooled_value = r_o_value;
    assign o_pool.frame_last   = r_o_last;

    a_req_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> o_room)
        else $error("request issued without room in the store stage");

    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en && r_s1.addr == i_req.addr) |=> r_fwd)
        else $error("same-entry read and write not forwarded");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && !s1_go) |=> (r_s1.valid && $stable(r_s1)))
        else $error("stalled store request changed");

    a_row_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> !(r_s1.first_row && r_s1.odd_row))
        else $error("first row of a channel flagged odd");

endmodule

`default_nettype wire

/* hdl/max_pool_3x3_stride2_top.sv */
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2_top
// Streaming 3x3, stride 2, pad 1 max pool over signed Q8.8 pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in channel-major raster order and emits each
// window maximum once its last in-range pixel has arrived, in channel, row,
// column order, with frame_last on the final output of a frame. A closed
// window column costs one read and one write-back of the column store (one
// entry per output column, single read and single write port); the write-back
// follows the read from the registered store stage, with forwarding, so the
// store sustains one pixel per cycle. Output valid is registered from the store
// stage holding the request of the pixel that closes the window. Pixel requests
// stall only while the output is held back with both the store stage and the
// output register occupied by results. The first row of each channel ignores
// the store, so no clearing pass is needed after reset or between channels.
`default_nettype none

module max_pool_3x3_stride2_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mpool_pix_if.sink    i_pix,
    mpool_pool_if.source o_pool
);
    import mpool_pkg::*;

    t_req req;
    logic room;

    mpool_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_room  (room),
        .o_req   (req)
    );

    mpool_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_room  (room),
        .o_pool  (o_pool)
    );

endmodule

`default_nettype wire
